@@ design/tafs_pkg.sv @@
`default_nettype none
package tafs_pkg;

  localparam int COS_FRAC     = 30;
  localparam int ACC_FRAC     = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 35;
  localparam int ZW           = 30;
  localparam int NORM_W       = 31;
  localparam int SQ_RAD_W     = 62;
  localparam int SQ_ROOT_W    = 31;
  localparam int SQ_REM_W     = 35;

  localparam logic signed [ZW-1:0] DEG90  = 30'sd94371840;
  localparam logic signed [ZW-1:0] DEG180 = 30'sd188743680;

  localparam logic signed [ZW-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
    30'sd1876857, 30'sd938658, 30'sd469357, 30'sd234682, 30'sd117342,
    30'sd58671, 30'sd29335, 30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
    30'sd917, 30'sd458, 30'sd229, 30'sd115, 30'sd57, 30'sd29, 30'sd14, 30'sd7
  };

  // sideband that rides along the divider and square root cells
  typedef struct packed {
    logic              vld;
    logic              tri_ok;
    logic              right;
    logic [2:0]        neg;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
  } side_t;

  // flags that ride along the cordic cells
  typedef struct packed {
    logic       vld;
    logic       tri_ok;
    logic       right;
    logic [2:0] neg;
  } flags_t;

endpackage
`default_nettype wire

@@ design/tafs_if.sv @@
`default_nettype none
interface tafs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] side_a;
  logic [15:0] side_b;
  logic [15:0] side_c;

  modport source (output valid, side_a, side_b, side_c, input ready);
  modport sink (input valid, side_a, side_b, side_c, output ready);
endinterface

interface tafs_out_if;
  logic        valid;
  logic        ready;
  logic        is_triangle;
  logic        is_right;
  logic [15:0] angle_small;
  logic [15:0] angle_middle;
  logic [15:0] angle_large;

  modport source (output valid, is_triangle, is_right, angle_small, angle_middle,
                  angle_large, input ready);
  modport sink (input valid, is_triangle, is_right, angle_small, angle_middle,
                angle_large, output ready);
endinterface
`default_nettype wire

@@ design/tafs_div_cell.sv @@
`default_nettype none
module tafs_div_cell #(
  parameter int W = 33
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [W-1:0]                  rem_in,
  input  logic [W-1:0]                  den_in,
  input  logic [tafs_pkg::COS_FRAC-1:0] quo_in,
  output logic [W-1:0]                  rem_out,
  output logic [W-1:0]                  den_out,
  output logic [tafs_pkg::COS_FRAC-1:0] quo_out
);
  import tafs_pkg::*;

  logic [W:0]   r2;
  logic         take;
  logic [W-1:0] rem_next;

  // one restoring division step, remainder stays below the divisor
  always_comb begin
    r2       = {rem_in, 1'b0};
    take     = r2 >= {1'b0, den_in};
    rem_next = take ? W'(r2 - {1'b0, den_in}) : W'(r2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      den_out <= den_in;
      quo_out <= {quo_in[COS_FRAC-2:0], take};
    end
  end
endmodule
`default_nettype wire

@@ design/tafs_sqrt_cell.sv @@
`default_nettype none
module tafs_sqrt_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tafs_pkg::SQ_RAD_W-1:0]  rad_in,
  input  logic [tafs_pkg::SQ_REM_W-1:0]  rem_in,
  input  logic [tafs_pkg::SQ_ROOT_W-1:0] root_in,
  input  logic [tafs_pkg::COS_FRAC-1:0]  cos_in,
  output logic [tafs_pkg::SQ_RAD_W-1:0]  rad_out,
  output logic [tafs_pkg::SQ_REM_W-1:0]  rem_out,
  output logic [tafs_pkg::SQ_ROOT_W-1:0] root_out,
  output logic [tafs_pkg::COS_FRAC-1:0]  cos_out
);
  import tafs_pkg::*;

  logic [SQ_REM_W-1:0]  cur;
  logic [SQ_REM_W-1:0]  trial;
  logic                 take;
  logic [SQ_REM_W-1:0]  rem_next;
  logic [SQ_ROOT_W-1:0] root_next;

  // one result bit per cell, two radicand bits consumed
  always_comb begin
    cur       = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
    trial     = SQ_REM_W'({root_in, 2'b01});
    take      = cur >= trial;
    rem_next  = take ? cur - trial : cur;
    root_next = {root_in[SQ_ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[SQ_RAD_W-3:0], 2'b00};
      rem_out  <= rem_next;
      root_out <= root_next;
      cos_out  <= cos_in;
    end
  end
endmodule
`default_nettype wire

@@ design/tafs_cordic_cell.sv @@
`default_nettype none
module tafs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tafs_pkg::CW-1:0]      x_in,
  input  logic signed [tafs_pkg::CW-1:0]      y_in,
  input  logic signed [tafs_pkg::ZW-1:0]      z_in,
  output logic signed [tafs_pkg::CW-1:0]      x_out,
  output logic signed [tafs_pkg::CW-1:0]      y_out,
  output logic signed [tafs_pkg::ZW-1:0]      z_out
);
  import tafs_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic                 up;

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    up = y_in > 0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (up) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + STEP_ANGLE[STEP];
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - STEP_ANGLE[STEP];
      end
    end
  end
endmodule
`default_nettype wire

@@ design/triangle_angles_from_sides.sv @@
`default_nettype none
// channel  dir  fields                                                   handshake
// req      in   side_a, side_b, side_c                                   valid/ready
// rsp      out  is_triangle, is_right, angle_small/middle/large           valid/ready
//
// fully pipelined: one triangle per cycle while rsp is not stalled
// pipeline: 3 front stages, 30 divider cells, 1 squaring stage, 31 square root
// cells, 24 cordic cells and the output register
// a stall on rsp freezes the whole pipeline; req.ready is low only while rsp is held
// reset clears the valid bits and the whole sideband and flag pipes, not the data registers
module triangle_angles_from_sides #(
  parameter int SIDE_BITS       = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  tafs_in_if.sink         req,
  tafs_out_if.source      rsp
);
  import tafs_pkg::*;

  localparam int SB       = SIDE_BITS;
  localparam int PW       = 2 * SB;
  localparam int W        = 2 * SB + 1;
  localparam int SD       = COS_FRAC + 1 + SQ_ROOT_W;
  localparam int SH       = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int RND      = 1 << (SH - 1);

  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // stage 1: sort
  logic          v1;
  logic [SB-1:0] s0_1, s1_1, s2_1;
  logic [SB-1:0] a, b, c, t;

  always_comb begin
    t = '0;
    a = SB'(req.side_a);
    b = SB'(req.side_b);
    c = SB'(req.side_c);
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      t = b; b = c; c = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_1 <= a;
      s1_1 <= b;
      s2_1 <= c;
    end
  end

  // stage 2: squares, cross products, triangle test
  logic          v2, tri2;
  logic [SB-1:0] s0_2, s1_2;
  logic [PW-1:0] sq0, sq1, sq2, p01, p02, p12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tri2 <= (s0_1 != '0) && ((SB + 1)'(s0_1) + (SB + 1)'(s1_1) > (SB + 1)'(s2_1));
      s0_2 <= s0_1;
      s1_2 <= s1_1;
      sq0  <= PW'(s0_1) * PW'(s0_1);
      sq1  <= PW'(s1_1) * PW'(s1_1);
      sq2  <= PW'(s2_1) * PW'(s2_1);
      p01  <= PW'(s0_1) * PW'(s1_1);
      p02  <= PW'(s0_1) * PW'(s2_1);
      p12  <= PW'(s1_1) * PW'(s2_1);
    end
  end

  // stage 3: cosine numerators, denominators, right test, normalization
  logic [W-1:0]      pos [3];
  logic [W-1:0]      pp [3];
  logic [W-1:0]      den3 [3];
  logic [W-1:0]      rem3 [3];
  logic [2:0]        neg3;
  logic [NORM_W-1:0] nx3, ny3;
  side_t             side3;

  always_comb begin
    pos[0]  = W'(sq1) + W'(sq2);
    pos[1]  = W'(sq0) + W'(sq2);
    pos[2]  = W'(sq0) + W'(sq1);
    pp[0]   = W'(sq0);
    pp[1]   = W'(sq1);
    pp[2]   = W'(sq2);
    den3[0] = {p12, 1'b0};
    den3[1] = {p02, 1'b0};
    den3[2] = {p01, 1'b0};
    for (int i = 0; i < 3; i++) begin
      neg3[i] = pp[i] > pos[i];
      rem3[i] = neg3[i] ? pp[i] - pos[i] : pos[i] - pp[i];
    end
    // bring the middle side into [2^30, 2^31)
    nx3 = NORM_W'(s1_2);
    ny3 = NORM_W'(s0_2);
    for (int k = 4; k >= 0; k--) begin
      if (nx3 < (NORM_W'(1) << (NORM_W - (1 << k)))) begin
        nx3 = nx3 << (1 << k);
        ny3 = ny3 << (1 << k);
      end
    end
  end

  side_t             side_pipe [SD+1];
  logic [W-1:0]      drem [3][COS_FRAC+1];
  logic [W-1:0]      dden [3][COS_FRAC+1];
  logic [COS_FRAC-1:0] dquo [3][COS_FRAC+1];

  always_comb begin
    side3.vld    = v2;
    side3.tri_ok = tri2;
    side3.right  = tri2 && (W'(sq0) + W'(sq1) == W'(sq2));
    side3.neg    = neg3;
    side3.nx     = nx3;
    side3.ny     = ny3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= SD; i++) begin
        side_pipe[i] <= '0;
      end
    end else if (adv) begin
      side_pipe[0] <= side3;
      for (int i = 1; i <= SD; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  // divider cells, one quotient bit each
  for (genvar l = 0; l < 3; l++) begin : g_div_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        drem[l][0] <= rem3[l];
        dden[l][0] <= den3[l];
        dquo[l][0] <= '0;
      end
    end

    for (genvar j = 0; j < COS_FRAC; j++) begin : g_div
      tafs_div_cell #(.W(W)) u_cell (
        .clk     (clk),
        .en      (adv),
        .rem_in  (drem[l][j]),
        .den_in  (dden[l][j]),
        .quo_in  (dquo[l][j]),
        .rem_out (drem[l][j+1]),
        .den_out (dden[l][j+1]),
        .quo_out (dquo[l][j+1])
      );
    end
  end

  // squaring stage: radicand for the sine
  logic [SQ_RAD_W-1:0]  srad  [3][SQ_ROOT_W+1];
  logic [SQ_REM_W-1:0]  srem  [3][SQ_ROOT_W+1];
  logic [SQ_ROOT_W-1:0] sroot [3][SQ_ROOT_W+1];
  logic [COS_FRAC-1:0]  scos  [3][SQ_ROOT_W+1];
  logic [2*COS_FRAC-1:0] c2 [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      c2[l] = (2 * COS_FRAC)'(dquo[l][COS_FRAC]) * (2 * COS_FRAC)'(dquo[l][COS_FRAC]);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_sqrt_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        srad[l][0]  <= SQ_RAD_W'((SQ_RAD_W'(1) << (2 * COS_FRAC)) - SQ_RAD_W'(c2[l]));
        srem[l][0]  <= '0;
        sroot[l][0] <= '0;
        scos[l][0]  <= dquo[l][COS_FRAC];
      end
    end

    for (genvar j = 0; j < SQ_ROOT_W; j++) begin : g_sqrt
      tafs_sqrt_cell u_cell (
        .clk      (clk),
        .en       (adv),
        .rad_in   (srad[l][j]),
        .rem_in   (srem[l][j]),
        .root_in  (sroot[l][j]),
        .cos_in   (scos[l][j]),
        .rad_out  (srad[l][j+1]),
        .rem_out  (srem[l][j+1]),
        .root_out (sroot[l][j+1]),
        .cos_out  (scos[l][j+1])
      );
    end
  end

  // cordic vectoring cells; lane 0 takes the normalized sides in the right case
  logic signed [CW-1:0] cx [3][CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [3][CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [3][CORDIC_STEPS+1];
  flags_t               fl_pipe [CORDIC_STEPS+1];

  always_comb begin
    fl_pipe[0].vld    = side_pipe[SD].vld;
    fl_pipe[0].tri_ok = side_pipe[SD].tri_ok;
    fl_pipe[0].right  = side_pipe[SD].right;
    fl_pipe[0].neg    = side_pipe[SD].neg;
  end

  for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_flags
    always_ff @(posedge clk) begin
      if (rst) begin
        fl_pipe[i] <= '0;
      end else if (adv) begin
        fl_pipe[i] <= fl_pipe[i-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_cordic_lane
    if (l == 0) begin : g_right_in
      assign cx[l][0] = side_pipe[SD].right ? CW'(side_pipe[SD].nx) : CW'(scos[l][SQ_ROOT_W]);
      assign cy[l][0] = side_pipe[SD].right ? CW'(side_pipe[SD].ny) : CW'(sroot[l][SQ_ROOT_W]);
    end else begin : g_cos_in
      assign cx[l][0] = CW'(scos[l][SQ_ROOT_W]);
      assign cy[l][0] = CW'(sroot[l][SQ_ROOT_W]);
    end
    assign cz[l][0] = '0;

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      tafs_cordic_cell #(.STEP(j)) u_cell (
        .clk   (clk),
        .en    (adv),
        .x_in  (cx[l][j]),
        .y_in  (cy[l][j]),
        .z_in  (cz[l][j]),
        .x_out (cx[l][j+1]),
        .y_out (cy[l][j+1]),
        .z_out (cz[l][j+1])
      );
    end
  end

  // output stage: fold obtuse angles, right case, clamp and round
  function automatic logic [15:0] to_out(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] cl;
    logic [ZW-1:0]        r;
    cl = z;
    if (cl < 0) cl = '0;
    if (cl > DEG180) cl = DEG180;
    r = ZW'(cl) + ZW'(RND);
    return 16'(r >> SH);
  endfunction

  logic signed [ZW-1:0] zf [3];
  logic signed [ZW-1:0] zr;
  flags_t               fo;

  always_comb begin
    fo = fl_pipe[CORDIC_STEPS];
    for (int l = 0; l < 3; l++) begin
      zf[l] = fo.neg[l] ? DEG180 - cz[l][CORDIC_STEPS] : cz[l][CORDIC_STEPS];
    end
    zr = cz[0][CORDIC_STEPS];
    if (zr < 0) zr = '0;
    if (zr > DEG90) zr = DEG90;
    if (fo.right) begin
      zf[0] = zr;
      zf[1] = DEG90 - zr;
      zf[2] = DEG90;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= fo.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.is_triangle  <= fo.tri_ok;
      rsp.is_right     <= fo.right;
      rsp.angle_small  <= fo.tri_ok ? to_out(zf[0]) : 16'd0;
      rsp.angle_middle <= fo.tri_ok ? to_out(zf[1]) : 16'd0;
      rsp.angle_large  <= fo.tri_ok ? to_out(zf[2]) : 16'd0;
    end
  end
endmodule
`default_nettype wire
